/* hw/rtl/tkss_pkg.sv */
package tkss_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgKeepTop = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTopK    = 2'd1;

  localparam int unsigned TopKW   = 6;
  localparam logic [TopKW-1:0] TopKReset = 6'd32;

  localparam int unsigned IdW    = 32;
  localparam int unsigned ScoreW = 32;

  // Input operation codes
  localparam logic OpOffer = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    doc_id;
    logic [ScoreW-1:0] score;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD    = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_SHIFT   = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    new_ent;
  } cell_ctrl_t;

  // What a cell shows its neighbors: its entry, and whether that entry
  // is occupied and scores at or below the offered score
  typedef struct packed {
    entry_t ent;
    logic   le;
  } cell_link_t;

endpackage

/* hw/rtl/tkss_cell.sv */
module tkss_cell (
  input  logic                clk_i,
  input  logic                occ_i,
  input  tkss_pkg::cell_ctrl_t ctrl_i,
  input  tkss_pkg::cell_link_t left_i,
  input  tkss_pkg::cell_link_t right_i,
  output tkss_pkg::cell_link_t link_o
);
  import tkss_pkg::*;

  entry_t ent_q, ent_d;
  logic   le;

  assign le = occ_i && (ent_q.score <= ctrl_i.new_ent.score);

  assign link_o.ent = ent_q;
  assign link_o.le  = le;

  always_comb begin
    ent_d = ent_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: ent_d = ent_q;
      // make room: entries above the offered score move one place up
      CMD_INSERT: begin
        if (!le) begin
          ent_d = left_i.le ? ctrl_i.new_ent : left_i.ent;
        end
      end
      // drop the head: entries at or below the offered score move down
      CMD_REPLACE: begin
        if (right_i.le) begin
          ent_d = right_i.ent;
        end else if (le) begin
          ent_d = ctrl_i.new_ent;
        end
      end
      CMD_SHIFT: ent_d = right_i.ent;
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

/* hw/rtl/top_k_score_selector_top.sv */
// Top-K score selector. Offers (operation 0) and flushes (operation 1) are
// taken on start_i while busy_o is low. The kept entries live in a chain of
// MAX_K cells kept sorted by ascending score, ties in arrival order, so cell
// 0 always holds the entry a full store replaces. An offer is absorbed in
// the cycle it is accepted, so offers stream at one per cycle; a
// pass-through offer gives its result beat in the next cycle, also at one
// per cycle. A flush of a non-empty store holds busy_o high while the
// chain shifts toward cell 0, one entry per cycle, and gives n result beats
// (n = entries kept) back to back from the head of the chain, each through
// the result registers; an empty flush, or a flush in pass-through mode,
// gives one beat in the next cycle and never raises busy_o. Each result
// beat is on the result ports for
// exactly one cycle, marked by res_strobe_o: there is no backpressure, so
// capture every beat. Write configuration only while the block is idle;
// cfg_ready_o is always high and unknown register indexes are ignored.
module top_k_score_selector_top #(
  parameter int unsigned MAX_K = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [tkss_pkg::IdW-1:0]      doc_id_i,
  input  logic [tkss_pkg::ScoreW-1:0]   score_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tkss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tkss_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          res_strobe_o,
  output logic [tkss_pkg::IdW-1:0]      out_doc_id_o,
  output logic [tkss_pkg::ScoreW-1:0]   out_score_o,
  output logic                          valid_res_o,
  output logic                          last_o
);
  import tkss_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_K + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              keep_top_q;
  logic [TopKW-1:0]  top_k_q;
  logic [CntW-1:0]   k_eff;

  logic              strobe_q, strobe_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  entry_t            out_q, out_d;

  logic              accept;
  logic              full;
  cell_ctrl_t        ctrl;

  cell_link_t        link  [MAX_K];
  cell_link_t        left  [MAX_K];
  cell_link_t        right [MAX_K];
  logic [MAX_K-1:0]  occ;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_top_q <= 1'b1;
      top_k_q    <= TopKReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgKeepTop: keep_top_q <= cfg_data_i[0];
        CfgTopK:    top_k_q    <= cfg_data_i[TopKW-1:0];
        default: ;
      endcase
    end
  end

  // Cap the requested depth at the chain length
  always_comb begin
    if (32'(top_k_q) > 32'(MAX_K)) begin
      k_eff = CntW'(MAX_K);
    end else begin
      k_eff = CntW'(top_k_q);
    end
  end

  assign busy_o = (state_q == ST_FLUSH);
  assign accept = start_i && !busy_o;
  assign full   = (count_q >= k_eff);

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    assign occ[g] = (CntW'(g) < count_q);

    // Neighbor wiring: the head sees an always-lower left side, the tail an
    // empty right side
    if (g == 0) begin : g_head
      assign left[g] = cell_link_t'{ent: '0, le: 1'b1};
    end else begin : g_left
      assign left[g] = link[g-1];
    end
    if (g == MAX_K - 1) begin : g_tail
      assign right[g] = cell_link_t'{ent: '0, le: 1'b0};
    end else begin : g_right
      assign right[g] = link[g+1];
    end

    tkss_cell u_cell (
      .clk_i   (clk_i),
      .occ_i   (occ[g]),
      .ctrl_i  (ctrl),
      .left_i  (left[g]),
      .right_i (right[g]),
      .link_o  (link[g])
    );
  end

  // Sequencing: decide the chain command, the kept count and the result beat
  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    ctrl.cmd         = CMD_HOLD;
    ctrl.new_ent     = '{doc_id: doc_id_i, score: score_i};
    strobe_d         = 1'b0;
    valid_d          = valid_q;
    last_d           = last_q;
    out_d            = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OpOffer) begin
            if (!keep_top_q) begin
              strobe_d = 1'b1;
              valid_d  = 1'b1;
              last_d   = 1'b1;
              out_d    = '{doc_id: doc_id_i, score: score_i};
            end else if (k_eff != '0) begin
              if (!full) begin
                ctrl.cmd = CMD_INSERT;
                count_d  = count_q + CntW'(1);
              end else if (score_i > link[0].ent.score) begin
                ctrl.cmd = CMD_REPLACE;
              end
            end
          end else begin
            if (!keep_top_q || count_q == '0) begin
              strobe_d = 1'b1;
              valid_d  = 1'b0;
              last_d   = 1'b1;
              out_d    = '0;
            end else begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        // emit the head, advance the chain toward it
        ctrl.cmd = CMD_SHIFT;
        strobe_d = 1'b1;
        valid_d  = 1'b1;
        last_d   = (count_q == CntW'(1));
        out_d    = link[0].ent;
        count_d  = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    valid_q <= valid_d;
    last_q  <= last_d;
    out_q   <= out_d;
  end

  assign res_strobe_o = strobe_q;
  assign valid_res_o  = valid_q;
  assign last_o       = last_q;
  assign out_doc_id_o = out_q.doc_id;
  assign out_score_o  = out_q.score;

  // A flush never runs on an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (count_q != '0))
    else $error("flush running with no kept entries");

  // The kept count never exceeds the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) <= 32'(MAX_K)))
    else $error("kept count beyond chain length");

  // The final flush step ends the flush with a marked last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && count_q == CntW'(1)) |=>
      (state_q == ST_IDLE && res_strobe_o && last_o && valid_res_o))
    else $error("flush did not close with a last beat");

  // A kept offer produces no result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OpOffer && keep_top_q) |=> !res_strobe_o)
    else $error("result beat after a kept offer");

  // Every result beat outside a flush is the last of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !$past(busy_o) && res_strobe_o) |-> last_o)
    else $error("single-beat result not marked last");

endmodule
